@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RBD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rbd_pkg.sv @@
// ----------------------------------------------------------------------------
// RLE block decoder package
// Types and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam logic [7:0] LIT_MAX  = 8'd127;  // highest literal header
  localparam logic [7:0] RUN_BIAS = 8'd126;  // run length = header - bias
  localparam logic [7:0] RUN_MIN  = 8'd2;
  localparam logic [7:0] RUN_MAX  = 8'd129;
  localparam logic [7:0] REP_LIT  = 8'd1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_LIT_CUT     = 2'd1,
    ST_RUN_MISSING = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       stream_end;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] repeat_count;
    status_t    status;
    logic       stream_done;
  } result_t;

endpackage

@@ rtl/rbd_in_if.sv @@
// ----------------------------------------------------------------------------
// RLE block decoder input channel
// Valid/ready channel carrying one encoded byte and its end-of-stream flag.
// ----------------------------------------------------------------------------
interface rbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       stream_end;

  modport source (output valid, output code_byte, output stream_end, input ready);
  modport sink   (input valid, input code_byte, input stream_end, output ready);
endinterface

@@ rtl/rbd_out_if.sv @@
// ----------------------------------------------------------------------------
// RLE block decoder output channel
// Valid/ready channel carrying one decoded byte, its repeat count and status.
// ----------------------------------------------------------------------------
interface rbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [7:0] repeat_count;
  logic [1:0] status;
  logic       stream_done;

  modport source (output valid, output out_byte, output repeat_count,
                  output status, output stream_done, input ready);
  modport sink   (input valid, input out_byte, input repeat_count,
                  input status, input stream_done, output ready);
endinterface

@@ rtl/rbd_in_stage.sv @@
// ----------------------------------------------------------------------------
// RLE block decoder input register
// Captures one request from the input channel and holds it for the decoder.
// ----------------------------------------------------------------------------
module rbd_in_stage (
  input  logic          clk,
  input  logic          rst,
  rbd_in_if.sink        in_ch,
  input  logic          take,
  output logic          item_v,
  output rbd_pkg::item_t item
);
  import rbd_pkg::*;

  // Accept whenever the register is empty or drains this cycle.
  assign in_ch.ready = !item_v || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_v <= 1'b0;
    end else if (in_ch.ready) begin
      item_v <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      item.code_byte  <= in_ch.code_byte;
      item.stream_end <= in_ch.stream_end;
    end
  end

endmodule

@@ rtl/rbd_core.sv @@
// ----------------------------------------------------------------------------
// RLE block decoder core
// Holds block phase and remaining count; decodes a byte per cycle unless held.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbd_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_v,
  input  rbd_pkg::item_t  item,
  input  logic            down_ready,
  output logic            take,
  output logic            res_push,
  output rbd_pkg::result_t result
);
  import rbd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LIT    = 2'd1,
    PH_RUN    = 2'd2
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] remaining, remaining_next;
  logic       has_result;
  logic [7:0] left;

  always_comb begin
    phase_next          = phase;
    remaining_next      = remaining;
    has_result          = 1'b0;
    result.out_byte     = 8'd0;
    result.repeat_count = 8'd0;
    result.status       = ST_OK;
    result.stream_done  = item.stream_end;
    left                = ((remaining == 8'd0) ? 8'd1 : remaining) - 8'd1;

    unique case (phase)
      PH_LIT: begin
        has_result          = 1'b1;
        result.out_byte     = item.code_byte;
        result.repeat_count = REP_LIT;
        remaining_next      = left;
        if (left == 8'd0) begin
          phase_next = PH_HEADER;
        end
        if (item.stream_end && left != 8'd0) begin
          result.status = ST_LIT_CUT;
        end
      end
      PH_RUN: begin
        has_result          = 1'b1;
        result.out_byte     = item.code_byte;
        result.repeat_count = remaining;
        phase_next          = PH_HEADER;
        remaining_next      = 8'd0;
      end
      default: begin
        // Header byte: reports only when it ends the stream.
        has_result = item.stream_end;
        if (item.code_byte <= LIT_MAX) begin
          remaining_next = item.code_byte + 8'd1;
          phase_next     = PH_LIT;
          result.status  = ST_LIT_CUT;
        end else begin
          remaining_next = item.code_byte - RUN_BIAS;
          phase_next     = PH_RUN;
          result.status  = ST_RUN_MISSING;
        end
      end
    endcase

    // Any stream end starts the next stream afresh.
    if (item.stream_end) begin
      phase_next     = PH_HEADER;
      remaining_next = 8'd0;
    end
  end

  assign take     = item_v && (!has_result || down_ready);
  assign res_push = item_v && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      remaining <= 8'd0;
    end else if (take) begin
      phase     <= phase_next;
      remaining <= remaining_next;
    end
  end

  `RBD_ASSERT_NEXT(a_end_resets, take && item.stream_end, phase == PH_HEADER && remaining == 8'd0, "stream end did not clear state")
  `RBD_ASSERT_SAME(a_lit_count, phase == PH_LIT, remaining != 8'd0, "literal phase with zero count")
  `RBD_ASSERT_SAME(a_run_range, phase == PH_RUN, remaining >= RUN_MIN && remaining <= RUN_MAX, "run length out of range")
  `RBD_ASSERT_SAME(a_status_only, res_push && result.repeat_count == 8'd0, result.stream_done && result.status != ST_OK, "status-only result without stream end")

endmodule

@@ rtl/rbd_out_stage.sv @@
// ----------------------------------------------------------------------------
// RLE block decoder result register
// Holds one decoded result until the output channel takes it.
// ----------------------------------------------------------------------------
module rbd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_push,
  input  rbd_pkg::result_t result,
  output logic             up_ready,
  rbd_out_if.source        out_ch
);
  import rbd_pkg::*;

  logic    out_v;
  result_t held;

  assign up_ready = !out_v || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (up_ready) begin
      out_v <= res_push;
    end
    if (res_push && up_ready) begin
      held <= result;
    end
  end

  assign out_ch.valid        = out_v;
  assign out_ch.out_byte     = held.out_byte;
  assign out_ch.repeat_count = held.repeat_count;
  assign out_ch.status       = held.status;
  assign out_ch.stream_done  = held.stream_done;

endmodule

@@ rtl/rle_block_decoder.sv @@
// ----------------------------------------------------------------------------
// RLE block decoder
// Byte-oriented run-length block decoder, top level.
// ----------------------------------------------------------------------------
// Accepts one encoded byte per clock and sustains that rate under continuous
// flow; each result passes the input register, then the result register,
// before it is offered on the output, and a stalled output backs up into the
// input. A header 0..127 opens a literal block of header+1
// bytes, each returned with repeat count 1; a header 128..255 makes the next
// byte come back once with repeat count header-126. Header bytes give no
// result unless they end the stream, in which case a status-only result
// (byte 0, count 0) flags the cut block. Any stream end returns the decoder to
// expecting a header.
module rle_block_decoder (
  input  logic       clk,
  input  logic       rst,
  rbd_in_if.sink     in_ch,
  rbd_out_if.source  out_ch
);
  import rbd_pkg::*;

  logic    item_v;
  item_t   item;
  logic    take;
  logic    res_push;
  result_t result;
  logic    up_ready;

  rbd_in_stage u_in_stage (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .take   (take),
    .item_v (item_v),
    .item   (item)
  );

  rbd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_v     (item_v),
    .item       (item),
    .down_ready (up_ready),
    .take       (take),
    .res_push   (res_push),
    .result     (result)
  );

  rbd_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .result   (result),
    .up_ready (up_ready),
    .out_ch   (out_ch)
  );

endmodule
